// File: hw/rtl/sci_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment/circle intersection: shared package
// Widths and pipeline constants used by the interfaces and the datapath.
// ----------------------------------------------------------------------------
package sci_pkg;

    localparam int RADIUS_WIDTH = 15;
    localparam int NUM_STAGES   = 6;

endpackage

// File: hw/rtl/sci_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment/circle intersection: channel interfaces
// Valid/ready channels for the input word (segment and circle) and for the
// result word.
// ----------------------------------------------------------------------------
interface sci_in_if #(
    parameter int COORD_WIDTH = 16
);
    import sci_pkg::*;

    logic                             valid;
    logic                             ready;
    logic signed [COORD_WIDTH-1:0]    start_x;
    logic signed [COORD_WIDTH-1:0]    start_y;
    logic signed [COORD_WIDTH-1:0]    end_x;
    logic signed [COORD_WIDTH-1:0]    end_y;
    logic signed [COORD_WIDTH-1:0]    center_x;
    logic signed [COORD_WIDTH-1:0]    center_y;
    logic        [RADIUS_WIDTH-1:0]   radius;

    modport source (
        output valid, start_x, start_y, end_x, end_y, center_x, center_y, radius,
        input  ready
    );

    modport sink (
        input  valid, start_x, start_y, end_x, end_y, center_x, center_y, radius,
        output ready
    );
endinterface

interface sci_out_if;
    logic valid;
    logic ready;
    logic crosses;

    modport source (
        output valid, crosses,
        input  ready
    );

    modport sink (
        input  valid, crosses,
        output ready
    );
endinterface

// File: hw/rtl/segment_circle_intersect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment/circle intersection test
// Reports whether a line segment meets a circle, using exact integer
// arithmetic in a six-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
// A word on the item channel carries the segment end points, the circle
// centre and the radius. Each accepted word gives exactly one word on the
// result channel, whose crosses bit is set when the segment meets the circle.
// Words leave in the order in which they arrived.
// The word passes six register stages, from the coordinate differences to the
// result register, whose word is shown on the result channel.
// While the receiver does not stall, one word is accepted in every cycle, so
// throughput is one word per cycle; the rate is set by the multiplier stages,
// each of which takes a new operand set in every cycle.
// When the receiver holds ready low, the result register keeps its word and
// the stages behind it fill; item ready falls only once every stage holds a
// word. Bubbles are closed up while the receiver stalls.
// Reset empties the pipeline by clearing the valid bits; data is not reset.
// ----------------------------------------------------------------------------
module segment_circle_intersect #(
    parameter int COORD_WIDTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    sci_in_if.sink    item,
    sci_out_if.source result
);
    import sci_pkg::*;

    localparam int D    = COORD_WIDTH + 1;
    localparam int P    = 2 * D;
    localparam int R2W  = 2 * RADIUS_WIDTH;
    localparam int QW   = (P + 1 > R2W) ? P + 1 : R2W;
    localparam int XW   = 2 * P;
    localparam int RLW  = R2W + P;
    localparam int CMPW = (XW > RLW) ? XW : RLW;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] en;

    // Stage 1: coordinate differences.
    logic signed [D-1:0] ax_e, ay_e, bx_e, by_e, cx_e, cy_e;
    logic signed [D-1:0] abx_reg, aby_reg, acx_reg, acy_reg, bcx_reg, bcy_reg;
    logic [RADIUS_WIDTH-1:0] r1_reg;

    // Stage 2: products.
    logic signed [P-1:0] cr1_reg, cr2_reg;
    logic signed [P-1:0] abx2_reg, aby2_reg, acx2_reg, acy2_reg, bcx2_reg, bcy2_reg;
    logic signed [P-1:0] d1a_reg, d1b_reg, d2a_reg, d2b_reg;
    logic [R2W-1:0]      r2_2_reg;

    // Stage 3: sums and flags.
    logic signed [P:0]   cross_s;
    logic signed [P:0]   dot1, dot2;
    logic [QW-1:0]       da2, db2, r2_q;
    logic [P-1:0]        cross_abs_next, len2_next;
    logic                near_next, proj_next;
    logic [P-1:0]        cross_abs_reg, len2_reg;
    logic [R2W-1:0]      r2_3_reg;
    logic                near_reg, proj_reg;

    // Stage 4: partial products.
    logic [P-1:0]        pp_hh_reg, pp_hl_reg, pp_ll_reg;
    logic [R2W+D-1:0]    rl_hi_reg, rl_lo_reg;
    logic                late_reg;

    // Stage 5: full cross square and radius-length product.
    logic [CMPW-1:0]     cross2_next, rl_next;
    logic [CMPW-1:0]     cross2_reg, rl_reg;
    logic                late5_reg;

    // Stage 6: result.
    logic                crosses_reg;

    always_comb
    begin
        en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || result.ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        valid_next[0] = item.valid;
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            valid_next[i] = valid_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    assign item.ready     = en[0];
    assign result.valid   = valid_reg[NUM_STAGES-1];
    assign result.crosses = crosses_reg;

    assign ax_e = {item.start_x[COORD_WIDTH-1], item.start_x};
    assign ay_e = {item.start_y[COORD_WIDTH-1], item.start_y};
    assign bx_e = {item.end_x[COORD_WIDTH-1], item.end_x};
    assign by_e = {item.end_y[COORD_WIDTH-1], item.end_y};
    assign cx_e = {item.center_x[COORD_WIDTH-1], item.center_x};
    assign cy_e = {item.center_y[COORD_WIDTH-1], item.center_y};

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            abx_reg <= bx_e - ax_e;
            aby_reg <= by_e - ay_e;
            acx_reg <= cx_e - ax_e;
            acy_reg <= cy_e - ay_e;
            bcx_reg <= cx_e - bx_e;
            bcy_reg <= cy_e - by_e;
            r1_reg  <= item.radius;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            cr1_reg  <= abx_reg * acy_reg;
            cr2_reg  <= aby_reg * acx_reg;
            abx2_reg <= abx_reg * abx_reg;
            aby2_reg <= aby_reg * aby_reg;
            acx2_reg <= acx_reg * acx_reg;
            acy2_reg <= acy_reg * acy_reg;
            bcx2_reg <= bcx_reg * bcx_reg;
            bcy2_reg <= bcy_reg * bcy_reg;
            d1a_reg  <= abx_reg * acx_reg;
            d1b_reg  <= aby_reg * acy_reg;
            d2a_reg  <= abx_reg * bcx_reg;
            d2b_reg  <= aby_reg * bcy_reg;
            r2_2_reg <= R2W'(r1_reg) * R2W'(r1_reg);
        end
    end

    // The endpoint distances use the squares of the centre offsets, whose
    // signs do not matter. The far-end projection holds when ab.bc <= 0.
    always_comb
    begin
        cross_s        = {cr1_reg[P-1], cr1_reg} - {cr2_reg[P-1], cr2_reg};
        cross_abs_next = cross_s[P] ? P'(-cross_s) : P'(cross_s);
        len2_next      = P'(abx2_reg) + P'(aby2_reg);
        da2            = QW'(P'(acx2_reg)) + QW'(P'(acy2_reg));
        db2            = QW'(P'(bcx2_reg)) + QW'(P'(bcy2_reg));
        r2_q           = QW'(r2_2_reg);
        near_next      = (da2 <= r2_q) || (db2 <= r2_q);
        dot1           = {d1a_reg[P-1], d1a_reg} + {d1b_reg[P-1], d1b_reg};
        dot2           = {d2a_reg[P-1], d2a_reg} + {d2b_reg[P-1], d2b_reg};
        proj_next      = !dot1[P] && (dot2[P] || (dot2 == '0));
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            cross_abs_reg <= cross_abs_next;
            len2_reg      <= len2_next;
            r2_3_reg      <= r2_2_reg;
            near_reg      <= near_next;
            proj_reg      <= proj_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            pp_hh_reg <= P'(cross_abs_reg[P-1:D]) * P'(cross_abs_reg[P-1:D]);
            pp_hl_reg <= P'(cross_abs_reg[P-1:D]) * P'(cross_abs_reg[D-1:0]);
            pp_ll_reg <= P'(cross_abs_reg[D-1:0]) * P'(cross_abs_reg[D-1:0]);
            rl_hi_reg <= (R2W+D)'(r2_3_reg) * (R2W+D)'(len2_reg[P-1:D]);
            rl_lo_reg <= (R2W+D)'(r2_3_reg) * (R2W+D)'(len2_reg[D-1:0]);
            late_reg  <= near_reg || proj_reg;
        end
    end

    always_comb
    begin
        cross2_next = (CMPW'(pp_hh_reg) << P) + (CMPW'(pp_hl_reg) << (D + 1))
                    + CMPW'(pp_ll_reg);
        rl_next     = (CMPW'(rl_hi_reg) << D) + CMPW'(rl_lo_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            cross2_reg <= cross2_next;
            rl_reg     <= rl_next;
            late5_reg  <= late_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            crosses_reg <= (cross2_reg < rl_reg) && late5_reg;
        end
    end

    a_full_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (($countones(valid_reg) == NUM_STAGES) && !result.ready) |-> !item.ready)
        else $error("item ready high while every stage is full and stalled");

    a_bubble_absorbs: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[0] |-> item.ready)
        else $error("empty first stage did not take a word");

    a_zero_bound_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[4] && en[5] && (rl_reg == '0)) |=> !result.crosses)
        else $error("hit reported for a zero radius or a degenerate segment");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && !valid_reg[4]) |=> !result.valid)
        else $error("result word repeated after it was taken");

endmodule
